// ===== design/pspq_pkg.sv =====
// package for the push switch press qualifier: codes, widths and reset values
`default_nettype none
package pspq_pkg;

   localparam int NUM_SWITCHES_DEFAULT = 4;
   localparam int TABLE_SLOTS = 4;

   localparam int TIME_W = 32;
   localparam int LIMIT_W = 16;
   localparam int MODES_W = 12;
   localparam int MATCH_W = 40;
   localparam int PORT_W = 8;
   localparam int PINS_W = 32;
   localparam int INDEX_W = 2;
   localparam int KIND_W = 3;

   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 8;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;

   localparam logic [LIMIT_W-1:0] LEVEL_MIN_RESET = 16'd50;
   localparam logic [LIMIT_W-1:0] LEVEL_MAX_RESET = 16'd1000;
   localparam logic [LIMIT_W-1:0] EDGE_MIN_RESET = 16'd50;

   typedef enum logic [KIND_W-1:0] {
      KIND_NONE      = 3'd0,
      KIND_NORMAL    = 3'd1,
      KIND_LONG      = 3'd2,
      KIND_EDGE_LONG = 3'd3,
      KIND_EDGE      = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      REG_LEVEL_MIN = 3'd0,
      REG_LEVEL_MAX = 3'd1,
      REG_EDGE_MIN  = 3'd2,
      REG_MODES     = 3'd3,
      REG_MATCH_0   = 3'd4,
      REG_MATCH_1   = 3'd5,
      REG_MATCH_2   = 3'd6,
      REG_MATCH_3   = 3'd7
   } reg_index_type;

endpackage
`default_nettype wire

// ===== design/push_switch_press_qualifier.sv =====
// top level of the push switch press qualifier
//
// Accepts one request per clock while no response is waiting, and answers with at most
// one press response: the request is captured in an input register, the table
// match, elapsed time compare and state update happen in one pass, and the press lands
// in the response register. A waiting response stalls the pass, and an empty input
// register still takes one more request. A request with tuser high is a
// level sample for the pending edge check; otherwise it is a pin event that is
// matched against the switch table. Registers sit on the APB port at byte address
// 8*i and should only be written while no request is in flight. No clearing pass
// is needed after reset.
`default_nettype none
module push_switch_press_qualifier #(
   parameter int NUM_SWITCHES = pspq_pkg::NUM_SWITCHES_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // port[7:0], pins[39:8], now_ms[71:40], level_asserted[72], zero fill
   input  wire logic [pspq_pkg::REQ_DATA_W-1:0]     req_tdata,
   // func[0]
   input  wire logic                                req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // switch_index[1:0], press_kind[4:2], zero fill
   output logic [pspq_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [pspq_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [pspq_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [pspq_pkg::CSR_DATA_W-1:0]          csr_prdata,
   output logic                                     csr_pready
);

   localparam int SLOTS = (NUM_SWITCHES < pspq_pkg::TABLE_SLOTS) ?
                          NUM_SWITCHES : pspq_pkg::TABLE_SLOTS;

   // configuration
   logic [pspq_pkg::LIMIT_W-1:0] level_min_ff, level_max_ff, edge_min_ff;
   logic [pspq_pkg::MODES_W-1:0] modes_ff;
   logic [pspq_pkg::MATCH_W-1:0] match_ff [pspq_pkg::TABLE_SLOTS];

   // input register
   logic                          stage_valid_ff;
   logic                          stage_func_ff;
   logic [pspq_pkg::PORT_W-1:0]   stage_port_ff;
   logic [pspq_pkg::PINS_W-1:0]   stage_pins_ff;
   logic [pspq_pkg::TIME_W-1:0]   stage_now_ff;
   logic                          stage_level_ff;

   // switch state
   logic [SLOTS-1:0]              armed_ff, armed_in;
   logic [pspq_pkg::TIME_W-1:0]   press_start_ff [SLOTS];
   logic [pspq_pkg::TIME_W-1:0]   press_start_in [SLOTS];
   logic                          edge_pending_ff, edge_pending_in;
   logic [pspq_pkg::INDEX_W-1:0]  edge_switch_ff, edge_switch_in;
   logic [pspq_pkg::TIME_W-1:0]   edge_start_ff, edge_start_in;
   pspq_pkg::kind_type            edge_kind_ff, edge_kind_in;

   // response register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [pspq_pkg::INDEX_W-1:0]  rsp_index_ff, rsp_index_in;
   pspq_pkg::kind_type            rsp_kind_ff, rsp_kind_in;

   logic                          advance;
   logic                          fire;
   logic                          csr_write;
   pspq_pkg::reg_index_type       csr_index;

   logic [SLOTS-1:0]              hit_onehot;
   logic                          hit_found;
   logic [pspq_pkg::INDEX_W-1:0]  hit_idx;
   logic                          hit_armed;
   logic [pspq_pkg::TIME_W-1:0]   hit_start;
   logic [pspq_pkg::KIND_W-1:0]   hit_mode;
   logic [pspq_pkg::TIME_W-1:0]   level_elapsed;
   logic [pspq_pkg::TIME_W-1:0]   edge_elapsed;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign fire       = stage_valid_ff && advance;
   assign req_tready = !stage_valid_ff || advance;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_kind_ff, rsp_index_ff};

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = pspq_pkg::reg_index_type'(csr_paddr[5:3]);

   always_comb begin
      case (csr_index)
         pspq_pkg::REG_LEVEL_MIN: csr_prdata = 64'(level_min_ff);
         pspq_pkg::REG_LEVEL_MAX: csr_prdata = 64'(level_max_ff);
         pspq_pkg::REG_EDGE_MIN:  csr_prdata = 64'(edge_min_ff);
         pspq_pkg::REG_MODES:     csr_prdata = 64'(modes_ff);
         pspq_pkg::REG_MATCH_0:   csr_prdata = 64'(match_ff[0]);
         pspq_pkg::REG_MATCH_1:   csr_prdata = 64'(match_ff[1]);
         pspq_pkg::REG_MATCH_2:   csr_prdata = 64'(match_ff[2]);
         pspq_pkg::REG_MATCH_3:   csr_prdata = 64'(match_ff[3]);
         default:                 csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_min_ff <= pspq_pkg::LEVEL_MIN_RESET;
         level_max_ff <= pspq_pkg::LEVEL_MAX_RESET;
         edge_min_ff  <= pspq_pkg::EDGE_MIN_RESET;
         modes_ff     <= '0;
         for (int i = 0; i < pspq_pkg::TABLE_SLOTS; i++) begin
            match_ff[i] <= '0;
         end
      end else if (csr_write) begin
         case (csr_index)
            pspq_pkg::REG_LEVEL_MIN: level_min_ff <= csr_pwdata[15:0];
            pspq_pkg::REG_LEVEL_MAX: level_max_ff <= csr_pwdata[15:0];
            pspq_pkg::REG_EDGE_MIN:  edge_min_ff  <= csr_pwdata[15:0];
            pspq_pkg::REG_MODES:     modes_ff     <= csr_pwdata[11:0];
            pspq_pkg::REG_MATCH_0:   match_ff[0]  <= csr_pwdata[39:0];
            pspq_pkg::REG_MATCH_1:   match_ff[1]  <= csr_pwdata[39:0];
            pspq_pkg::REG_MATCH_2:   match_ff[2]  <= csr_pwdata[39:0];
            pspq_pkg::REG_MATCH_3:   match_ff[3]  <= csr_pwdata[39:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_tready) begin
         stage_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         stage_func_ff  <= req_tuser;
         stage_port_ff  <= req_tdata[7:0];
         stage_pins_ff  <= req_tdata[39:8];
         stage_now_ff   <= req_tdata[71:40];
         stage_level_ff <= req_tdata[72];
      end
   end

   // first matching table entry
   always_comb begin
      hit_onehot = '0;
      hit_found  = 1'b0;
      hit_idx    = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (!hit_found && match_ff[i] == {stage_port_ff, stage_pins_ff}) begin
            hit_found     = 1'b1;
            hit_onehot[i] = 1'b1;
            hit_idx       = pspq_pkg::INDEX_W'(i);
         end
      end
   end

   always_comb begin
      hit_armed = 1'b0;
      hit_start = '0;
      hit_mode  = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (hit_onehot[i]) begin
            hit_armed = armed_ff[i];
            hit_start = press_start_ff[i];
            hit_mode  = modes_ff[3*i +: 3];
         end
      end
   end

   assign level_elapsed = stage_now_ff - hit_start;
   assign edge_elapsed  = stage_now_ff - edge_start_ff;

   // compare and update
   always_comb begin
      armed_in        = armed_ff;
      press_start_in  = press_start_ff;
      edge_pending_in = edge_pending_ff;
      edge_switch_in  = edge_switch_ff;
      edge_start_in   = edge_start_ff;
      edge_kind_in    = edge_kind_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_index_in    = rsp_index_ff;
      rsp_kind_in     = rsp_kind_ff;
      if (fire) begin
         if (stage_func_ff) begin
            if (edge_pending_ff) begin
               if (!stage_level_ff) begin
                  edge_pending_in = 1'b0;
               end else if (edge_elapsed > 32'(edge_min_ff)) begin
                  edge_pending_in = 1'b0;
                  rsp_valid_in    = 1'b1;
                  rsp_index_in    = edge_switch_ff;
                  rsp_kind_in     = edge_kind_ff;
               end
            end
         end else if (hit_found) begin
            case (hit_mode)
               pspq_pkg::KIND_NORMAL: begin
                  for (int i = 0; i < SLOTS; i++) begin
                     if (hit_onehot[i]) begin
                        if (!hit_armed) begin
                           armed_in[i]       = 1'b1;
                           press_start_in[i] = stage_now_ff;
                        end else if (level_elapsed > 32'(level_max_ff)) begin
                           armed_in[i] = 1'b0;
                        end else if (level_elapsed > 32'(level_min_ff)) begin
                           armed_in[i] = 1'b0;
                        end
                     end
                  end
                  if (hit_armed && level_elapsed <= 32'(level_max_ff) &&
                      level_elapsed > 32'(level_min_ff)) begin
                     rsp_valid_in = 1'b1;
                     rsp_index_in = hit_idx;
                     rsp_kind_in  = pspq_pkg::KIND_NORMAL;
                  end
               end
               pspq_pkg::KIND_EDGE_LONG, pspq_pkg::KIND_EDGE: begin
                  edge_pending_in = 1'b1;
                  edge_switch_in  = hit_idx;
                  edge_start_in   = stage_now_ff;
                  edge_kind_in    = pspq_pkg::kind_type'(hit_mode);
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff        <= '0;
         edge_pending_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         armed_ff        <= armed_in;
         edge_pending_ff <= edge_pending_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      press_start_ff <= press_start_in;
      edge_switch_ff <= edge_switch_in;
      edge_start_ff  <= edge_start_in;
      edge_kind_ff   <= edge_kind_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_kind_ff    <= rsp_kind_in;
   end

endmodule
`default_nettype wire

// ===== design/pspq_checker.sv =====
// port checker for the push switch press qualifier and its bind
`default_nettype none
module pspq_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_tready,
   input wire logic                               rsp_tvalid,
   input wire logic                               rsp_tready,
   input wire logic [pspq_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input wire logic                               csr_pready
);

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // only normal, edge long and edge presses are reported, with zero fill above the kind
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[4:2] == pspq_pkg::KIND_NORMAL ||
                      rsp_tdata[4:2] == pspq_pkg::KIND_EDGE_LONG ||
                      rsp_tdata[4:2] == pspq_pkg::KIND_EDGE) && rsp_tdata[7:5] == 3'b000)
      else $error("response with a press kind that never qualifies");

   // requests are held back only behind a full response register
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("request stalled with empty response register");

   // no response right after reset, and the csr port never waits
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid && csr_pready)
      else $error("response or csr stall after reset");

endmodule

bind push_switch_press_qualifier pspq_checker u_pspq_checker (.*);
`default_nettype wire
